[rtl/i2crts_pkg.sv]
// Shared types and codes for the I2C register transaction sequencer.
// No dependencies.
package i2crts_pkg;

  localparam int MAX_BURST_DEF = 255;
  localparam logic [23:0] TIMEOUT_RESET = 24'd10000000;
  localparam int RQ_DEPTH = 4;
  localparam int RQ_AW = $clog2(RQ_DEPTH);
  localparam int RQ_CW = $clog2(RQ_DEPTH + 1);
  localparam int RES_MAX = 3;

  // command codes
  localparam logic [2:0] CMD_BEGIN_WR = 3'd0;
  localparam logic [2:0] CMD_BEGIN_RD = 3'd1;
  localparam logic [2:0] CMD_WDATA    = 3'd2;
  localparam logic [2:0] CMD_EVENT    = 3'd3;
  localparam logic [2:0] CMD_TICK     = 3'd4;

  // bus event kinds
  localparam logic [2:0] EV_START_SENT = 3'd0;
  localparam logic [2:0] EV_ADDR_ACK   = 3'd1;
  localparam logic [2:0] EV_ADDR_NACK  = 3'd2;
  localparam logic [2:0] EV_BYTE_SENT  = 3'd3;
  localparam logic [2:0] EV_BYTE_RECV  = 3'd4;

  // actions
  localparam logic [2:0] ACT_NONE  = 3'd0;
  localparam logic [2:0] ACT_START = 3'd1;
  localparam logic [2:0] ACT_SEND  = 3'd2;
  localparam logic [2:0] ACT_RECV  = 3'd3;
  localparam logic [2:0] ACT_STOP  = 3'd4;
  localparam logic [2:0] ACT_DATA  = 3'd5;
  localparam logic [2:0] ACT_DONE  = 3'd6;

  // status codes
  localparam logic [3:0] ST_OK           = 4'd0;
  localparam logic [3:0] ST_BAD_LEN      = 4'd1;
  localparam logic [3:0] ST_START_TOUT   = 4'd2;
  localparam logic [3:0] ST_ADDR_TOUT    = 4'd3;
  localparam logic [3:0] ST_ADDR_NACK    = 4'd4;
  localparam logic [3:0] ST_REG_FAIL     = 4'd5;
  localparam logic [3:0] ST_DATA_FAIL    = 4'd6;
  localparam logic [3:0] ST_RESTART_TOUT = 4'd7;
  localparam logic [3:0] ST_READ_TOUT    = 4'd8;

  typedef struct packed {
    logic [2:0] cmd;
    logic [6:0] bus_addr;
    logic [7:0] reg_addr;
    logic [7:0] burst_length;
    logic [7:0] data_byte;
    logic [2:0] event_kind;
  } req_t;

  typedef struct packed {
    logic [2:0] action;
    logic [7:0] byte_value;
    logic       ack_after_receive;
    logic [3:0] status;
    logic       last;
  } res_t;

  // results produced by one request, written to the queue together
  typedef struct packed {
    logic [1:0]             cnt;
    res_t [RES_MAX-1:0]     res;
  } push_t;

endpackage

[rtl/i2crts_seq.sv]
// Request register, transaction state and per-request result generation.
// Depends on i2crts_pkg.
module i2crts_seq #(
  parameter int MAX_BURST = i2crts_pkg::MAX_BURST_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                req_valid,
  output logic                req_stall,
  input  i2crts_pkg::req_t    req,
  input  logic                cfg_we,
  input  logic [23:0]         cfg_timeout_limit,
  input  logic                room,
  output i2crts_pkg::push_t   push
);
  import i2crts_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_START     = 4'd1,
    PH_ADDR_W    = 4'd2,
    PH_REG       = 4'd3,
    PH_WDATA     = 4'd4,
    PH_DATA_SENT = 4'd5,
    PH_RESTART   = 4'd6,
    PH_ADDR_R    = 4'd7,
    PH_RX        = 4'd8
  } phase_t;

  localparam logic [15:0] MAXB = 16'(MAX_BURST);

  logic        s1_valid_r, s1_valid_nxt;
  req_t        s1_r;
  phase_t      phase_r, phase_nxt;
  logic        is_read_r, is_read_nxt;
  logic [6:0]  tgt_r, tgt_nxt;
  logic [7:0]  reg_idx_r, reg_idx_nxt;
  logic [7:0]  left_r, left_nxt;
  logic [23:0] wait_r, wait_nxt;
  logic [23:0] tout_r;
  logic        adv;
  logic        accept;
  logic [1:0]  n;
  res_t [RES_MAX-1:0] res_a;
  logic [7:0]  left_dec;
  logic [23:0] wait_inc;

  function automatic res_t mk(logic [2:0] act, logic [7:0] b, logic ack, logic [3:0] st);
    res_t r;
    r.action            = act;
    r.byte_value        = b;
    r.ack_after_receive = ack;
    r.status            = st;
    r.last              = 1'b0;
    return r;
  endfunction

  function automatic logic [3:0] tout_status(phase_t p);
    logic [3:0] s;
    case (p)
      PH_START:     s = ST_START_TOUT;
      PH_ADDR_W:    s = ST_ADDR_TOUT;
      PH_REG:       s = ST_REG_FAIL;
      PH_DATA_SENT: s = ST_DATA_FAIL;
      PH_RESTART:   s = ST_RESTART_TOUT;
      PH_ADDR_R:    s = ST_ADDR_TOUT;
      PH_RX:        s = ST_READ_TOUT;
      default:      s = ST_OK;
    endcase
    return s;
  endfunction

  assign adv       = s1_valid_r && room;
  assign req_stall = s1_valid_r && !room;
  assign accept    = req_valid && !req_stall;
  assign left_dec  = (left_r != 8'd0) ? left_r - 8'd1 : 8'd0;
  assign wait_inc  = (wait_r != 24'hFFFFFF) ? wait_r + 24'd1 : wait_r;

  always_comb begin
    s1_valid_nxt = accept ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
    phase_nxt    = phase_r;
    is_read_nxt  = is_read_r;
    tgt_nxt      = tgt_r;
    reg_idx_nxt  = reg_idx_r;
    left_nxt     = left_r;
    wait_nxt     = wait_r;
    n            = 2'd0;
    res_a        = '0;
    if (adv) begin
      case (s1_r.cmd)
        CMD_BEGIN_WR, CMD_BEGIN_RD: begin
          if (phase_r == PH_IDLE) begin
            if (s1_r.burst_length == 8'd0 || {8'd0, s1_r.burst_length} > MAXB) begin
              res_a[n] = mk(ACT_DONE, 8'd0, 1'b0, ST_BAD_LEN);
              n = n + 2'd1;
            end else begin
              is_read_nxt = (s1_r.cmd == CMD_BEGIN_RD);
              tgt_nxt     = s1_r.bus_addr;
              reg_idx_nxt = s1_r.reg_addr;
              left_nxt    = s1_r.burst_length;
              phase_nxt   = PH_START;
              wait_nxt    = 24'd0;
              res_a[n] = mk(ACT_START, 8'd0, 1'b0, ST_OK);
              n = n + 2'd1;
            end
          end
        end
        CMD_WDATA: begin
          if (phase_r == PH_WDATA) begin
            left_nxt  = left_dec;
            phase_nxt = PH_DATA_SENT;
            wait_nxt  = 24'd0;
            res_a[n] = mk(ACT_SEND, s1_r.data_byte, 1'b0, ST_OK);
            n = n + 2'd1;
          end
        end
        CMD_EVENT: begin
          case (phase_r)
            PH_START: begin
              if (s1_r.event_kind == EV_START_SENT) begin
                phase_nxt = PH_ADDR_W;
                wait_nxt  = 24'd0;
                res_a[n] = mk(ACT_SEND, {tgt_r, 1'b0}, 1'b0, ST_OK);
                n = n + 2'd1;
              end
            end
            PH_ADDR_W, PH_ADDR_R: begin
              if (s1_r.event_kind == EV_ADDR_NACK) begin
                phase_nxt = PH_IDLE;
                wait_nxt  = 24'd0;
                left_nxt  = 8'd0;
                res_a[n] = mk(ACT_DONE, 8'd0, 1'b0, ST_ADDR_NACK);
                n = n + 2'd1;
              end else if (s1_r.event_kind == EV_ADDR_ACK) begin
                wait_nxt = 24'd0;
                if (phase_r == PH_ADDR_W) begin
                  phase_nxt = PH_REG;
                  res_a[n] = mk(ACT_SEND, reg_idx_r, 1'b0, ST_OK);
                  n = n + 2'd1;
                end else begin
                  phase_nxt = PH_RX;
                  if (left_r <= 8'd1) begin
                    res_a[n] = mk(ACT_RECV, 8'd0, 1'b0, ST_OK);
                    n = n + 2'd1;
                    res_a[n] = mk(ACT_STOP, 8'd0, 1'b0, ST_OK);
                    n = n + 2'd1;
                  end else begin
                    res_a[n] = mk(ACT_RECV, 8'd0, 1'b1, ST_OK);
                    n = n + 2'd1;
                  end
                end
              end
            end
            PH_REG: begin
              if (s1_r.event_kind == EV_BYTE_SENT) begin
                wait_nxt = 24'd0;
                if (is_read_r) begin
                  phase_nxt = PH_RESTART;
                  res_a[n] = mk(ACT_START, 8'd0, 1'b0, ST_OK);
                  n = n + 2'd1;
                end else begin
                  phase_nxt = PH_WDATA;
                end
              end
            end
            PH_DATA_SENT: begin
              if (s1_r.event_kind == EV_BYTE_SENT) begin
                wait_nxt = 24'd0;
                if (left_r == 8'd0) begin
                  phase_nxt = PH_IDLE;
                  res_a[n] = mk(ACT_STOP, 8'd0, 1'b0, ST_OK);
                  n = n + 2'd1;
                  res_a[n] = mk(ACT_DONE, 8'd0, 1'b0, ST_OK);
                  n = n + 2'd1;
                end else begin
                  phase_nxt = PH_WDATA;
                end
              end
            end
            PH_RESTART: begin
              if (s1_r.event_kind == EV_START_SENT) begin
                phase_nxt = PH_ADDR_R;
                wait_nxt  = 24'd0;
                res_a[n] = mk(ACT_SEND, {tgt_r, 1'b1}, 1'b0, ST_OK);
                n = n + 2'd1;
              end
            end
            PH_RX: begin
              if (s1_r.event_kind == EV_BYTE_RECV) begin
                wait_nxt = 24'd0;
                left_nxt = left_dec;
                res_a[n] = mk(ACT_DATA, s1_r.data_byte, 1'b0, ST_OK);
                n = n + 2'd1;
                if (left_dec == 8'd0) begin
                  phase_nxt = PH_IDLE;
                  res_a[n] = mk(ACT_DONE, 8'd0, 1'b0, ST_OK);
                  n = n + 2'd1;
                end else if (left_dec == 8'd1) begin
                  res_a[n] = mk(ACT_RECV, 8'd0, 1'b0, ST_OK);
                  n = n + 2'd1;
                  res_a[n] = mk(ACT_STOP, 8'd0, 1'b0, ST_OK);
                  n = n + 2'd1;
                end else begin
                  res_a[n] = mk(ACT_RECV, 8'd0, 1'b1, ST_OK);
                  n = n + 2'd1;
                end
              end
            end
            default: begin
            end
          endcase
        end
        CMD_TICK: begin
          if (phase_r != PH_IDLE && phase_r != PH_WDATA) begin
            wait_nxt = wait_inc;
            if (wait_inc >= tout_r) begin
              phase_nxt = PH_IDLE;
              wait_nxt  = 24'd0;
              left_nxt  = 8'd0;
              res_a[n] = mk(ACT_DONE, 8'd0, 1'b0, tout_status(phase_r));
              n = n + 2'd1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    // flag the final result of this request
    for (int i = 0; i < RES_MAX; i++) begin
      res_a[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
    end
  end

  assign push.cnt = n;
  assign push.res = res_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      phase_r    <= PH_IDLE;
      is_read_r  <= 1'b0;
      tgt_r      <= 7'd0;
      reg_idx_r  <= 8'd0;
      left_r     <= 8'd0;
      wait_r     <= 24'd0;
      tout_r     <= TIMEOUT_RESET;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      phase_r    <= phase_nxt;
      is_read_r  <= is_read_nxt;
      tgt_r      <= tgt_nxt;
      reg_idx_r  <= reg_idx_nxt;
      left_r     <= left_nxt;
      wait_r     <= wait_nxt;
      if (cfg_we) begin
        tout_r <= cfg_timeout_limit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= req;
    end
  end

endmodule

[rtl/i2crts_resq.sv]
// Result queue: takes up to three results a cycle, hands out one unless stalled.
// Depends on i2crts_pkg.
module i2crts_resq (
  input  logic                clk,
  input  logic                rst_n,
  input  i2crts_pkg::push_t   push,
  output logic                room,
  output logic                q_valid,
  input  logic                q_stall,
  output i2crts_pkg::res_t    q_head
);
  import i2crts_pkg::*;

  res_t             mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RQ_CW-1:0] count_r, count_nxt;
  logic             pop;

  assign q_valid = (count_r != '0);
  assign pop     = q_valid && !q_stall;
  assign room    = (count_r <= RQ_CW'(RQ_DEPTH - RES_MAX));
  assign q_head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + RQ_AW'(push.cnt);
    rd_ptr_nxt = rd_ptr_r + RQ_AW'(pop);
    count_nxt  = count_r + RQ_CW'(push.cnt) - RQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < RES_MAX; i++) begin
      if (2'(i) < push.cnt) begin
        mem_r[wr_ptr_r + RQ_AW'(i)] <= push.res[i];
      end
    end
  end

endmodule

[rtl/i2c_register_transaction_sequencer.sv]
// I2C register transaction sequencer, top level.
// Path: an accepted request is held in the request register and decoded once
//   the queue has room; its results enter the result queue, which feeds out_.
// Throughput: one request a cycle while each yields at most one result and the
//   output keeps up; results leave a 4-entry queue one a cycle unless stalled.
// Reset: synchronous, active low; idle, queue empty, timeout limit 10000000.
// Depends on i2crts_pkg, i2crts_seq, i2crts_resq.
module i2c_register_transaction_sequencer #(
  parameter int MAX_BURST = i2crts_pkg::MAX_BURST_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [23:0] cfg_timeout_limit,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_cmd,
  input  logic [6:0]  in_bus_addr,
  input  logic [7:0]  in_reg_addr,
  input  logic [7:0]  in_burst_length,
  input  logic [7:0]  in_data_byte,
  input  logic [2:0]  in_event_kind,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_action,
  output logic [7:0]  out_byte_value,
  output logic        out_ack_after_receive,
  output logic [3:0]  out_status,
  output logic        out_last
);
  import i2crts_pkg::*;

  req_t  req;
  push_t push;
  res_t  head;
  logic  room;

  assign req.cmd          = in_cmd;
  assign req.bus_addr     = in_bus_addr;
  assign req.reg_addr     = in_reg_addr;
  assign req.burst_length = in_burst_length;
  assign req.data_byte    = in_data_byte;
  assign req.event_kind   = in_event_kind;

  // Request register plus phase logic. A held request is decoded only when
  // the queue has space for the worst case of three results, so the input
  // stalls only while the output side is backed up.
  i2crts_seq #(
    .MAX_BURST(MAX_BURST)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (in_valid),
    .req_stall        (in_stall),
    .req              (req),
    .cfg_we           (cfg_we),
    .cfg_timeout_limit(cfg_timeout_limit),
    .room             (room),
    .push             (push)
  );

  // Results from one request land in the queue together and drain in order.
  i2crts_resq u_resq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (push),
    .room   (room),
    .q_valid(out_valid),
    .q_stall(out_stall),
    .q_head (head)
  );

  assign out_action            = head.action;
  assign out_byte_value        = head.byte_value;
  assign out_ack_after_receive = head.ack_after_receive;
  assign out_status            = head.status;
  assign out_last              = head.last;

endmodule

[rtl/i2crts_checker.sv]
// Port-level checks for the I2C register transaction sequencer, with bind.
// Depends on i2crts_pkg and i2c_register_transaction_sequencer.
module i2crts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_action,
  input logic [7:0]  out_byte_value,
  input logic        out_ack_after_receive,
  input logic [3:0]  out_status,
  input logic        out_last
);
  import i2crts_pkg::*;

  // nothing queued straight after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // a held result keeps its action, byte, status and last flag
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_action)
      && $stable(out_byte_value) && $stable(out_status) && $stable(out_last))
    else $error("stalled result changed");

  // done always closes the run of a request
  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_DONE |-> out_last)
    else $error("done result not marked last");

  a_status_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_DONE |-> out_status == ST_OK)
    else $error("status set on a non-done result");

  a_ack_recv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_RECV |-> !out_ack_after_receive)
    else $error("ack flag set outside receive next");

endmodule

bind i2c_register_transaction_sequencer i2crts_checker u_chk (
  .clk                  (clk),
  .rst_n                (rst_n),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_action           (out_action),
  .out_byte_value       (out_byte_value),
  .out_ack_after_receive(out_ack_after_receive),
  .out_status           (out_status),
  .out_last             (out_last)
);

[bench/tb_i2c_register_transaction_sequencer.sv]
`timescale 1ns / 100ps
// Self-checking bench for the I2C register transaction sequencer: queued requests in,
// bus actions out, each checked against an in-bench model of the transaction sequence.
// Depends on i2crts_pkg and i2c_register_transaction_sequencer.
module tb_i2c_register_transaction_sequencer;
  import i2crts_pkg::*;

  // sequencer phases as the model tracks them
  typedef enum logic [3:0] {
    PH_IDLE, PH_START, PH_ADDR_W, PH_REG, PH_WDATA, PH_DATA_SENT, PH_RESTART, PH_ADDR_R, PH_RX
  } seq_phase_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [23:0] cfg_timeout_limit = 24'd0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_cmd = 3'd0;
  logic [6:0]  in_bus_addr = 7'd0;
  logic [7:0]  in_reg_addr = 8'd0;
  logic [7:0]  in_burst_length = 8'd0;
  logic [7:0]  in_data_byte = 8'd0;
  logic [2:0]  in_event_kind = 3'd0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_action;
  logic [7:0]  out_byte_value;
  logic        out_ack_after_receive;
  logic [3:0]  out_status;
  logic        out_last;

  // requests waiting to be offered, and bus actions predicted but not yet seen
  req_t req_backlog[$];
  res_t bus_actions_due[$];
  res_t staged[$];
  req_t cur_req;
  int   queued = 0;
  int   errors = 0;

  // idling control: calm turns off random gaps on both sides, hold_req asks for one long hold-off
  bit   calm = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_left = 0;

  // model state, reset values as the block's
  seq_phase_t  seq_ph = PH_IDLE;
  logic        rd_txn = 1'b0;
  logic [6:0]  tgt_addr = 7'd0;
  logic [7:0]  reg_idx = 8'd0;
  logic [7:0]  bytes_left = 8'd0;
  logic [23:0] wait_ticks = 24'd0;
  logic [23:0] timeout_lim = TIMEOUT_RESET;

  i2c_register_transaction_sequencer dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_we                (cfg_we),
    .cfg_timeout_limit     (cfg_timeout_limit),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_cmd                (in_cmd),
    .in_bus_addr           (in_bus_addr),
    .in_reg_addr           (in_reg_addr),
    .in_burst_length       (in_burst_length),
    .in_data_byte          (in_data_byte),
    .in_event_kind         (in_event_kind),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_action            (out_action),
    .out_byte_value        (out_byte_value),
    .out_ack_after_receive (out_ack_after_receive),
    .out_status            (out_status),
    .out_last              (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- model

  function automatic void issue(logic [2:0] act, logic [7:0] b, logic ack, logic [3:0] st);
    res_t r;
    r.action = act;
    r.byte_value = b;
    r.ack_after_receive = ack;
    r.status = st;
    r.last = 1'b0;
    staged.push_back(r);
  endfunction

  // every phase change restarts the wait count
  function automatic void enter(seq_phase_t p);
    seq_ph = p;
    wait_ticks = 24'd0;
  endfunction

  function automatic void close_run(logic [3:0] st);
    enter(PH_IDLE);
    bytes_left = 8'd0;
    issue(ACT_DONE, 8'd0, 1'b0, st);
  endfunction

  // Advances the transaction sequence by one accepted request and queues the bus actions
  // it produces; the final one of the group carries last.
  function automatic void advance_sequencer(req_t r);
    logic [3:0] tst;
    staged.delete();
    case (r.cmd)
      CMD_BEGIN_WR, CMD_BEGIN_RD: begin
        // a begin while busy is dropped silently
        if (seq_ph == PH_IDLE) begin
          if (r.burst_length == 8'd0 || int'(r.burst_length) > MAX_BURST_DEF) begin
            issue(ACT_DONE, 8'd0, 1'b0, ST_BAD_LEN);
          end else begin
            rd_txn = (r.cmd == CMD_BEGIN_RD);
            tgt_addr = r.bus_addr;
            reg_idx = r.reg_addr;
            bytes_left = r.burst_length;
            enter(PH_START);
            issue(ACT_START, 8'd0, 1'b0, ST_OK);
          end
        end
      end
      CMD_WDATA: begin
        if (seq_ph == PH_WDATA) begin
          if (bytes_left != 8'd0) bytes_left--;
          enter(PH_DATA_SENT);
          issue(ACT_SEND, r.data_byte, 1'b0, ST_OK);
        end
      end
      CMD_EVENT: begin
        case (seq_ph)
          PH_START: begin
            if (r.event_kind == EV_START_SENT) begin
              enter(PH_ADDR_W);
              issue(ACT_SEND, {tgt_addr, 1'b0}, 1'b0, ST_OK);
            end
          end
          PH_ADDR_W, PH_ADDR_R: begin
            if (r.event_kind == EV_ADDR_NACK) begin
              // no STOP after an address nack
              close_run(ST_ADDR_NACK);
            end else if (r.event_kind == EV_ADDR_ACK) begin
              if (seq_ph == PH_ADDR_W) begin
                enter(PH_REG);
                issue(ACT_SEND, reg_idx, 1'b0, ST_OK);
              end else begin
                enter(PH_RX);
                issue(ACT_RECV, 8'd0, bytes_left > 8'd1, ST_OK);
                if (bytes_left <= 8'd1) issue(ACT_STOP, 8'd0, 1'b0, ST_OK);
              end
            end
          end
          PH_REG: begin
            if (r.event_kind == EV_BYTE_SENT) begin
              if (rd_txn) begin
                enter(PH_RESTART);
                issue(ACT_START, 8'd0, 1'b0, ST_OK);
              end else begin
                enter(PH_WDATA);
              end
            end
          end
          PH_DATA_SENT: begin
            if (r.event_kind == EV_BYTE_SENT) begin
              if (bytes_left == 8'd0) begin
                issue(ACT_STOP, 8'd0, 1'b0, ST_OK);
                close_run(ST_OK);
              end else begin
                enter(PH_WDATA);
              end
            end
          end
          PH_RESTART: begin
            if (r.event_kind == EV_START_SENT) begin
              enter(PH_ADDR_R);
              issue(ACT_SEND, {tgt_addr, 1'b1}, 1'b0, ST_OK);
            end
          end
          PH_RX: begin
            if (r.event_kind == EV_BYTE_RECV) begin
              issue(ACT_DATA, r.data_byte, 1'b0, ST_OK);
              if (bytes_left != 8'd0) bytes_left--;
              if (bytes_left == 8'd0) begin
                close_run(ST_OK);
              end else begin
                // NACK and STOP go out once the second-last byte is in
                enter(PH_RX);
                issue(ACT_RECV, 8'd0, bytes_left != 8'd1, ST_OK);
                if (bytes_left == 8'd1) issue(ACT_STOP, 8'd0, 1'b0, ST_OK);
              end
            end
          end
          default: ;
        endcase
      end
      CMD_TICK: begin
        // ticks only count while the bus owes us an event
        if (seq_ph != PH_IDLE && seq_ph != PH_WDATA) begin
          if (wait_ticks != 24'hFFFFFF) wait_ticks++;
          if (wait_ticks >= timeout_lim) begin
            case (seq_ph)
              PH_START:             tst = ST_START_TOUT;
              PH_ADDR_W, PH_ADDR_R: tst = ST_ADDR_TOUT;
              PH_REG:               tst = ST_REG_FAIL;
              PH_DATA_SENT:         tst = ST_DATA_FAIL;
              PH_RESTART:           tst = ST_RESTART_TOUT;
              PH_RX:                tst = ST_READ_TOUT;
              default:              tst = ST_OK;
            endcase
            close_run(tst);
          end
        end
      end
      default: ;
    endcase
    if (staged.size() != 0) staged[staged.size() - 1].last = 1'b1;
    foreach (staged[i]) bus_actions_due.push_back(staged[i]);
  endfunction

  // ---------------------------------------------------------------- driver

  // Offers the next request unless idling; a stalled request is held as it is.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) advance_sequencer(cur_req);
      if (!in_valid || !in_stall) begin
        if (req_backlog.size() != 0 && (calm || $urandom_range(99) >= 17)) begin
          cur_req = req_backlog.pop_front();
          in_valid <= 1'b1;
          in_cmd <= cur_req.cmd;
          in_bus_addr <= cur_req.bus_addr;
          in_reg_addr <= cur_req.reg_addr;
          in_burst_length <= cur_req.burst_length;
          in_data_byte <= cur_req.data_byte;
          in_event_kind <= cur_req.event_kind;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- result side

  // Random stall, plus one long hold-off that lets the result queue fill and back up
  // into the request channel.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req && !hold_done) begin
        hold_left = 120;
        hold_done = 1'b1;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 17);
      end
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (bus_actions_due.size() == 0) begin
        $error("action %0d arrived with nothing outstanding", out_action);
        errors++;
      end else begin
        want = bus_actions_due.pop_front();
        check_field("action", want.action, out_action);
        check_field("byte_value", want.byte_value, out_byte_value);
        check_field("ack_after_receive", want.ack_after_receive, out_ack_after_receive);
        check_field("status", want.status, out_status);
        check_field("last", want.last, out_last);
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  // random everywhere except command and event kind; callers override what matters
  function automatic req_t make_req(logic [2:0] cmd, logic [2:0] kind);
    req_t r;
    r.cmd = cmd;
    r.bus_addr = 7'($urandom);
    r.reg_addr = 8'($urandom);
    r.burst_length = 8'($urandom);
    r.data_byte = 8'($urandom);
    r.event_kind = kind;
    return r;
  endfunction

  task automatic add(req_t r);
    req_backlog.push_back(r);
    queued++;
  endtask

  // queues a request, sometimes preceded by ticks or a stray request
  task automatic put(req_t r, int tick_pct);
    if ($urandom_range(99) < tick_pct) begin
      repeat ($urandom_range(1, 3)) add(make_req(CMD_TICK, 3'($urandom_range(0, 4))));
    end
    if ($urandom_range(99) < 4) add(make_req(3'($urandom_range(0, 7)), 3'($urandom_range(0, 4))));
    add(r);
  endtask

  // one well-formed write or read with random content; an occasional nack or bad length
  task automatic queue_transaction(int tick_pct);
    req_t r;
    bit   rd;
    int   n;
    int   len;
    rd = 1'($urandom_range(1));
    n = $urandom_range(99);
    len = (n < 3) ? 0 : (n < 85) ? $urandom_range(1, 4) : $urandom_range(5, 12);
    r = make_req(rd ? CMD_BEGIN_RD : CMD_BEGIN_WR, EV_START_SENT);
    r.burst_length = 8'(len);
    put(r, tick_pct);
    put(make_req(CMD_EVENT, EV_START_SENT), tick_pct);
    put(make_req(CMD_EVENT, ($urandom_range(11) == 0) ? EV_ADDR_NACK : EV_ADDR_ACK), tick_pct);
    put(make_req(CMD_EVENT, EV_BYTE_SENT), tick_pct);
    if (!rd) begin
      repeat (len) begin
        put(make_req(CMD_WDATA, EV_BYTE_SENT), tick_pct);
        put(make_req(CMD_EVENT, EV_BYTE_SENT), tick_pct);
      end
    end else begin
      put(make_req(CMD_EVENT, EV_START_SENT), tick_pct);
      put(make_req(CMD_EVENT, ($urandom_range(11) == 0) ? EV_ADDR_NACK : EV_ADDR_ACK), tick_pct);
      repeat (len) put(make_req(CMD_EVENT, EV_BYTE_RECV), tick_pct);
    end
  endtask

  // Waits until every request is taken and every action seen, then lets the clock run on
  // with nothing offered so the request register and the result queue settle.
  task automatic drain();
    @(negedge clk);
    while (req_backlog.size() != 0 || in_valid || bus_actions_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_limit(logic [23:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_timeout_limit <= v;
    timeout_lim = v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic run_phase(int n_items, int tick_pct);
    int start;
    start = queued;
    while (queued - start < n_items) queue_transaction(tick_pct);
    drain();
  endtask

  initial begin
    req_t r;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: zero length, idle noise, a one-byte write, a one-byte read, address nack
    r = make_req(CMD_BEGIN_WR, EV_START_SENT);
    r.bus_addr = 7'd127;
    r.reg_addr = 8'd255;
    r.burst_length = 8'd0;
    add(r);
    r = make_req(CMD_BEGIN_RD, EV_START_SENT);
    r.burst_length = 8'd0;
    add(r);
    add(make_req(CMD_EVENT, EV_START_SENT));
    add(make_req(CMD_TICK, EV_START_SENT));

    r = make_req(CMD_BEGIN_WR, EV_START_SENT);
    r.bus_addr = 7'd127;
    r.reg_addr = 8'd0;
    r.burst_length = 8'd1;
    add(r);
    add(make_req(CMD_WDATA, EV_START_SENT));           // not waiting for data yet
    add(make_req(CMD_EVENT, EV_START_SENT));
    r = make_req(CMD_BEGIN_RD, EV_START_SENT);         // begin while busy
    r.burst_length = 8'd3;
    add(r);
    add(make_req(CMD_EVENT, EV_ADDR_ACK));
    add(make_req(CMD_EVENT, EV_BYTE_RECV));            // wrong kind for this phase
    add(make_req(CMD_EVENT, EV_BYTE_SENT));
    add(make_req(CMD_TICK, EV_START_SENT));            // ticks ignored while awaiting data
    r = make_req(CMD_WDATA, EV_START_SENT);
    r.data_byte = 8'd255;
    add(r);
    add(make_req(CMD_EVENT, EV_BYTE_SENT));

    r = make_req(CMD_BEGIN_RD, EV_START_SENT);
    r.bus_addr = 7'd0;
    r.reg_addr = 8'd255;
    r.burst_length = 8'd1;
    add(r);
    add(make_req(CMD_EVENT, EV_START_SENT));
    add(make_req(CMD_EVENT, EV_ADDR_ACK));
    add(make_req(CMD_EVENT, EV_BYTE_SENT));
    add(make_req(CMD_EVENT, EV_START_SENT));
    add(make_req(CMD_EVENT, EV_ADDR_ACK));
    r = make_req(CMD_EVENT, EV_BYTE_RECV);
    r.data_byte = 8'd0;
    add(r);

    r = make_req(CMD_BEGIN_WR, EV_START_SENT);
    r.bus_addr = 7'h55;
    r.burst_length = 8'd255;
    add(r);
    add(make_req(CMD_EVENT, EV_START_SENT));
    add(make_req(CMD_EVENT, EV_ADDR_NACK));
    add(make_req(3'd7, EV_BYTE_RECV));                 // unused command
    drain();

    // tightest limit: any tick aborts, so runs end in every phase that counts ticks
    write_limit(24'd1);
    r = make_req(CMD_BEGIN_WR, EV_START_SENT);
    r.burst_length = 8'd2;
    add(r);
    add(make_req(CMD_TICK, EV_START_SENT));
    r = make_req(CMD_BEGIN_RD, EV_START_SENT);
    r.burst_length = 8'd2;
    add(r);
    add(make_req(CMD_EVENT, EV_START_SENT));
    add(make_req(CMD_TICK, EV_START_SENT));
    run_phase(70, 8);

    // widest limit, no idling on either side
    write_limit(24'hFFFFFF);
    calm = 1'b1;
    run_phase(70, 20);
    calm = 1'b0;

    // short limit with the long result hold-off
    write_limit(24'($urandom_range(2, 5)));
    hold_req = 1'b1;
    run_phase(90, 25);

    write_limit(24'($urandom_range(1, 3)));
    run_phase(50, 15);

    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule
